// File: src/ivc_pkg.sv
`timescale 1ns / 1ps
package ivc_pkg;

  // Widths of the intermediate values; all follow from the 32-bit fields.
  localparam int FIELD_W = 32;
  localparam int SQ_W    = 2 * FIELD_W;          // se squared
  localparam int DEN_W   = SQ_W + 1;             // sum of two squares
  localparam int TERM_W  = FIELD_W + SQ_W;       // beta magnitude times square
  localparam int NUM_W   = TERM_W + 1;           // signed sum of two terms, as magnitude
  localparam int PROD_W  = 2 * SQ_W;             // product of the two squares
  localparam int BETA_QW = NUM_W - SQ_W;         // quotient bits of the pooled beta
  localparam int SE_QW   = PROD_W - SQ_W;        // quotient bits of the pooled variance
  localparam int ROOT_W  = SE_QW / 2;

  localparam logic [BETA_QW-1:0] BETA_POS_MAX = BETA_QW'(33'h0_7FFF_FFFF);
  localparam logic [BETA_QW-1:0] BETA_NEG_MAX = BETA_QW'(33'h0_8000_0000);

  // Control bits that travel with every word down the pipeline.
  typedef struct packed {
    logic inv;
    logic last;
    logic neg;
  } ctl_t;

  localparam int CTL_W = $bits(ctl_t);

endpackage

// File: src/ivc_if.sv
`timescale 1ns / 1ps
interface ivc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] beta_first;
  logic [31:0] beta_second;
  logic [31:0] se_first;
  logic [31:0] se_second;
  logic        last_in;

  modport source (output valid, beta_first, beta_second, se_first, se_second, last_in,
                  input ready);
  modport sink (input valid, beta_first, beta_second, se_first, se_second, last_in,
                output ready);
endinterface

interface ivc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] combined_beta;
  logic [31:0] combined_se;
  logic        invalid;
  logic        last_out;

  modport source (output valid, combined_beta, combined_se, invalid, last_out,
                  input ready);
  modport sink (input valid, combined_beta, combined_se, invalid, last_out,
                output ready);
endinterface

// File: src/ivc_front.sv
`timescale 1ns / 1ps
module ivc_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [31:0]                in_beta_first,
  input  logic [31:0]                in_beta_second,
  input  logic [31:0]                in_se_first,
  input  logic [31:0]                in_se_second,
  input  logic                       in_last,
  output logic                       out_valid,
  output logic [ivc_pkg::NUM_W-1:0]  out_num,
  output logic [ivc_pkg::PROD_W-1:0] out_prod,
  output logic [ivc_pkg::DEN_W-1:0]  out_den,
  output ivc_pkg::ctl_t              out_ctl
);

  localparam int SW = ivc_pkg::SQ_W;
  localparam int FW = ivc_pkg::FIELD_W;
  localparam int TW = ivc_pkg::TERM_W;

  // Stage 1: squares, magnitudes and signs.
  logic                 v1_r;
  logic [SW-1:0]        sq1_r, sq2_r;
  logic [FW-1:0]        m1_r, m2_r;
  logic                 n1_r, n2_r;
  ivc_pkg::ctl_t        c1_r;
  // Stage 2: 32 by 32 partial products.
  logic                 v2_r;
  logic [SW-1:0]        pa1_r, pb1_r, pa2_r, pb2_r;
  logic [SW-1:0]        pll_r, plh_r, phl_r, phh_r;
  logic [ivc_pkg::DEN_W-1:0] den2_r, den3_r, den4_r;
  logic                 n12_r, n22_r;
  ivc_pkg::ctl_t        c2_r;
  // Stage 3: assembled products.
  logic                 v3_r;
  logic [TW-1:0]        t1_r, t2_r;
  logic [ivc_pkg::PROD_W-1:0] p3_r, p4_r;
  logic                 n13_r, n23_r;
  ivc_pkg::ctl_t        c3_r;
  // Stage 4: signed sum as magnitude and sign.
  logic                 v4_r;
  logic [ivc_pkg::NUM_W-1:0] num4_r;
  ivc_pkg::ctl_t        c4_r;

  logic                 neg1, neg2;
  logic [SW-1:0]        sq1_nxt, sq2_nxt;
  logic [ivc_pkg::NUM_W-1:0] num_nxt;
  logic                 neg_nxt;

  assign neg1    = in_beta_first[FW-1];
  assign neg2    = in_beta_second[FW-1];
  assign sq1_nxt = in_se_first * in_se_first;
  assign sq2_nxt = in_se_second * in_se_second;

  always_comb begin
    if (n13_r == n23_r) begin
      num_nxt = {1'b0, t1_r} + {1'b0, t2_r};
      neg_nxt = n13_r;
    end else if (t1_r >= t2_r) begin
      num_nxt = {1'b0, t1_r - t2_r};
      neg_nxt = n13_r;
    end else begin
      num_nxt = {1'b0, t2_r - t1_r};
      neg_nxt = n23_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq1_r    <= sq1_nxt;
      sq2_r    <= sq2_nxt;
      m1_r     <= neg1 ? (~in_beta_first + FW'(1)) : in_beta_first;
      m2_r     <= neg2 ? (~in_beta_second + FW'(1)) : in_beta_second;
      n1_r     <= neg1;
      n2_r     <= neg2;
      c1_r.inv  <= (in_se_first == '0) || (in_se_second == '0);
      c1_r.last <= in_last;
      c1_r.neg  <= 1'b0;

      pa1_r  <= m1_r * sq2_r[FW-1:0];
      pb1_r  <= m1_r * sq2_r[SW-1:FW];
      pa2_r  <= m2_r * sq1_r[FW-1:0];
      pb2_r  <= m2_r * sq1_r[SW-1:FW];
      pll_r  <= sq1_r[FW-1:0] * sq2_r[FW-1:0];
      plh_r  <= sq1_r[FW-1:0] * sq2_r[SW-1:FW];
      phl_r  <= sq1_r[SW-1:FW] * sq2_r[FW-1:0];
      phh_r  <= sq1_r[SW-1:FW] * sq2_r[SW-1:FW];
      den2_r <= {1'b0, sq1_r} + {1'b0, sq2_r};
      n12_r  <= n1_r;
      n22_r  <= n2_r;
      c2_r   <= c1_r;

      t1_r   <= {{FW{1'b0}}, pa1_r} + {pb1_r, {FW{1'b0}}};
      t2_r   <= {{FW{1'b0}}, pa2_r} + {pb2_r, {FW{1'b0}}};
      p3_r   <= {{SW{1'b0}}, pll_r} + {{FW{1'b0}}, plh_r, {FW{1'b0}}}
              + {{FW{1'b0}}, phl_r, {FW{1'b0}}} + {phh_r, {SW{1'b0}}};
      den3_r <= den2_r;
      n13_r  <= n12_r;
      n23_r  <= n22_r;
      c3_r   <= c2_r;

      num4_r   <= num_nxt;
      p4_r     <= p3_r;
      den4_r   <= den3_r;
      c4_r.inv  <= c3_r.inv;
      c4_r.last <= c3_r.last;
      c4_r.neg  <= neg_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_num   = num4_r;
  assign out_prod  = p4_r;
  assign out_den   = den4_r;
  assign out_ctl   = c4_r;

endmodule

// File: src/ivc_divider.sv
`timescale 1ns / 1ps
module ivc_divider #(
  parameter int QW = 64,
  parameter int SW = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [ivc_pkg::DEN_W-2+QW:0]     in_num,
  input  logic [ivc_pkg::DEN_W-1:0]        in_den,
  input  logic [SW-1:0]                    in_side,
  output logic                             out_valid,
  output logic [QW-1:0]                    out_quo,
  output logic [ivc_pkg::DEN_W-1:0]        out_den,
  output logic [SW-1:0]                    out_side
);

  localparam int DW = ivc_pkg::DEN_W;

  // One quotient bit per stage. The numerator's low bits shift out of nq
  // while quotient bits shift in behind them.
  logic          v_r   [QW];
  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] nq_r  [QW];
  logic [DW-1:0] den_r [QW];
  logic [SW-1:0] sd_r  [QW];

  logic [DW-1:0] rem_i [QW];
  logic [QW-1:0] nq_i  [QW];
  logic [DW-1:0] den_i [QW];
  logic [DW-1:0] rem_n [QW];
  logic [QW-1:0] nq_n  [QW];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      logic [DW:0] sh;
      logic        ge;
      if (k == 0) begin
        rem_i[k] = {1'b0, in_num[DW-2+QW:QW]};
        nq_i[k]  = in_num[QW-1:0];
        den_i[k] = in_den;
      end else begin
        rem_i[k] = rem_r[k-1];
        nq_i[k]  = nq_r[k-1];
        den_i[k] = den_r[k-1];
      end
      sh       = {rem_i[k], nq_i[k][QW-1]};
      ge       = sh >= {1'b0, den_i[k]};
      rem_n[k] = ge ? DW'(sh - {1'b0, den_i[k]}) : sh[DW-1:0];
      nq_n[k]  = {nq_i[k][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QW; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 1; k < QW; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= in_side;
      for (int k = 1; k < QW; k++) sd_r[k] <= sd_r[k-1];
      for (int k = 0; k < QW; k++) begin
        rem_r[k] <= rem_n[k];
        nq_r[k]  <= nq_n[k];
        den_r[k] <= den_i[k];
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_quo   = nq_r[QW-1];
  assign out_den   = den_r[QW-1];
  assign out_side  = sd_r[QW-1];

endmodule

// File: src/ivc_sqrt.sv
`timescale 1ns / 1ps
module ivc_sqrt #(
  parameter int SW = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [ivc_pkg::SE_QW-1:0]    in_x,
  input  logic [SW-1:0]                in_side,
  output logic                         out_valid,
  output logic [ivc_pkg::ROOT_W-1:0]   out_root,
  output logic [SW-1:0]                out_side
);

  localparam int RW = ivc_pkg::ROOT_W;
  localparam int XW = ivc_pkg::SE_QW;
  localparam int MW = RW + 2;

  // Floored square root, one result bit (two radicand bits) per stage.
  logic          v_r    [RW];
  logic [MW-1:0] rem_r  [RW];
  logic [RW-1:0] root_r [RW];
  logic [XW-1:0] x_r    [RW];
  logic [SW-1:0] sd_r   [RW];

  logic [MW-1:0] rem_i  [RW];
  logic [RW-1:0] root_i [RW];
  logic [XW-1:0] x_i    [RW];
  logic [MW-1:0] rem_n  [RW];
  logic [RW-1:0] root_n [RW];

  always_comb begin
    for (int k = 0; k < RW; k++) begin
      logic [MW+1:0] r4;
      logic [MW+1:0] trial;
      logic          ge;
      if (k == 0) begin
        rem_i[k]  = '0;
        root_i[k] = '0;
        x_i[k]    = in_x;
      end else begin
        rem_i[k]  = rem_r[k-1];
        root_i[k] = root_r[k-1];
        x_i[k]    = x_r[k-1];
      end
      r4        = {rem_i[k], x_i[k][XW-1:XW-2]};
      trial     = {2'b00, root_i[k], 2'b01};
      ge        = r4 >= trial;
      rem_n[k]  = ge ? MW'(r4 - trial) : r4[MW-1:0];
      root_n[k] = {root_i[k][RW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < RW; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 1; k < RW; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= in_side;
      for (int k = 1; k < RW; k++) sd_r[k] <= sd_r[k-1];
      for (int k = 0; k < RW; k++) begin
        rem_r[k]  <= rem_n[k];
        root_r[k] <= root_n[k];
        x_r[k]    <= {x_i[k][XW-3:0], 2'b00};
      end
    end
  end

  assign out_valid = v_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_side  = sd_r[RW-1];

endmodule

// File: src/inverse_variance_combiner.sv
`timescale 1ns / 1ps
// Inverse-variance weighted mean of two effect estimates, Q16.16 throughout.
// Input channel in_ch carries two signed estimates, two unsigned standard
// errors and a last marker; each accepted word yields exactly one word on
// out_ch with the pooled estimate, the pooled standard error, an invalid flag
// and the copied marker. Words leave in the order they arrived.
// Throughput is one word per cycle while out_ch is not stalled. From acceptance
// to out_ch, a word passes four front stages, a 64-stage divider for
// the pooled variance, a 33-stage divider for the pooled estimate, a 32-stage
// square root and the output register. Each divider and root stage resolves
// one result bit with one wide compare and subtract, which sets the depth.
// When either standard error is zero the word is flagged invalid and both
// results read as zero.
// The whole pipeline advances together while the output register is empty or
// being taken; when the receiver holds out_ch.ready low with a word waiting,
// every stage holds and in_ch.ready drops, so nothing is lost or repeated.
// Synchronous active-low reset clears all valid bits; the block accepts words
// in the first cycle after reset is released.
module inverse_variance_combiner (
  input logic        clk,
  input logic        rst_n,
  ivc_in_if.sink     in_ch,
  ivc_out_if.source  out_ch
);

  localparam int NW  = ivc_pkg::NUM_W;
  localparam int CW  = ivc_pkg::CTL_W;
  localparam int BQW = ivc_pkg::BETA_QW;
  localparam int SQW = ivc_pkg::SE_QW;

  // Global advance: every stage moves when the output register can take a word.
  logic en;

  logic                           fr_valid;
  logic [NW-1:0]                  fr_num;
  logic [ivc_pkg::PROD_W-1:0]     fr_prod;
  logic [ivc_pkg::DEN_W-1:0]      fr_den;
  ivc_pkg::ctl_t                  fr_ctl;

  logic                           dv_valid;
  logic [SQW-1:0]                 dv_quo;
  logic [ivc_pkg::DEN_W-1:0]      dv_den;
  logic [NW+CW-1:0]               dv_side;

  logic                           db_valid;
  logic [BQW-1:0]                 db_quo;
  logic [ivc_pkg::DEN_W-1:0]      db_den_unused;
  logic [SQW+CW-1:0]              db_side;

  logic                           rt_valid;
  logic [ivc_pkg::ROOT_W-1:0]     rt_root;
  logic [BQW+CW-1:0]              rt_side;

  ivc_pkg::ctl_t                  rt_ctl;
  logic [BQW-1:0]                 rt_q;
  logic [31:0]                    qmag;
  logic [31:0]                    beta_nxt;
  logic [31:0]                    se_nxt;

  logic        out_valid_r;
  logic [31:0] beta_r;
  logic [31:0] se_r;
  logic        inv_r;
  logic        last_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  ivc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .in_valid       (in_ch.valid),
    .in_beta_first  (in_ch.beta_first),
    .in_beta_second (in_ch.beta_second),
    .in_se_first    (in_ch.se_first),
    .in_se_second   (in_ch.se_second),
    .in_last        (in_ch.last_in),
    .out_valid      (fr_valid),
    .out_num        (fr_num),
    .out_prod       (fr_prod),
    .out_den        (fr_den),
    .out_ctl        (fr_ctl)
  );

  // Pooled variance: product of the squares over their sum. The beta
  // numerator rides along and the divisor comes out with the quotient.
  ivc_divider #(.QW(64), .SW(NW + CW)) u_div_var (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .in_num    (fr_prod),
    .in_den    (fr_den),
    .in_side   ({fr_num, fr_ctl}),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_den   (dv_den),
    .out_side  (dv_side)
  );

  // Pooled estimate magnitude, reusing the same divisor.
  ivc_divider #(.QW(33), .SW(SQW + CW)) u_div_beta (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dv_valid),
    .in_num    (dv_side[NW+CW-1:CW]),
    .in_den    (dv_den),
    .in_side   ({dv_quo, dv_side[CW-1:0]}),
    .out_valid (db_valid),
    .out_quo   (db_quo),
    .out_den   (db_den_unused),
    .out_side  (db_side)
  );

  ivc_sqrt #(.SW(BQW + CW)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (db_valid),
    .in_x      (db_side[SQW+CW-1:CW]),
    .in_side   ({db_quo, db_side[CW-1:0]}),
    .out_valid (rt_valid),
    .out_root  (rt_root),
    .out_side  (rt_side)
  );

  assign rt_ctl = ivc_pkg::ctl_t'(rt_side[CW-1:0]);
  assign rt_q   = rt_side[BQW+CW-1:CW];

  // Sign and clamp. The quotient never really leaves range, but the clamp
  // keeps the most negative value reachable only on the negative side.
  always_comb begin
    if (rt_ctl.neg) begin
      qmag     = (rt_q > ivc_pkg::BETA_NEG_MAX) ? ivc_pkg::BETA_NEG_MAX[31:0] : rt_q[31:0];
      beta_nxt = ~qmag + 32'd1;
    end else begin
      qmag     = '0;
      beta_nxt = (rt_q > ivc_pkg::BETA_POS_MAX) ? ivc_pkg::BETA_POS_MAX[31:0] : rt_q[31:0];
    end
    se_nxt = rt_root;
    if (rt_ctl.inv) begin
      beta_nxt = '0;
      se_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= rt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      beta_r <= beta_nxt;
      se_r   <= se_nxt;
      inv_r  <= rt_ctl.inv;
      last_r <= rt_ctl.last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.combined_beta = beta_r;
  assign out_ch.combined_se   = se_r;
  assign out_ch.invalid       = inv_r;
  assign out_ch.last_out      = last_r;

  // An invalid word always carries zero results.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.invalid |-> (out_ch.combined_beta == '0) && (out_ch.combined_se == '0))
    else $error("invalid word with nonzero results");

  // A waiting word that is not taken stalls the input side in the same cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted while output stalled");

  // Reset leaves the output empty.
  assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid right after reset");

endmodule
